// ===== hdl/owb_pkg.sv =====
// ----------------------------------------------------------------------------
// owb_pkg
// Types, codes and constants shared by the 1-Wire bus master and its core.
// ----------------------------------------------------------------------------
package owb_pkg;

	localparam int unsigned TimerW   = 10;
	localparam int unsigned NumRegs  = 8;
	localparam int unsigned CfgIdxW  = 4;
	localparam int unsigned BitCntW  = 4;
	localparam int unsigned ByteBits = 8;

	typedef logic [TimerW-1:0] ticks_t;

	// Whole register file, one slot time per entry.
	typedef logic [NumRegs-1:0][TimerW-1:0] cfg_file_t;

	// Register indexes on the configuration port.
	typedef enum logic [CfgIdxW-1:0] {
		REG_RESET_LOW      = 4'd0,
		REG_PRESENCE_WAIT  = 4'd1,
		REG_RESET_TAIL     = 4'd2,
		REG_SHORT_LOW      = 4'd3,
		REG_LONG_LOW       = 4'd4,
		REG_WRITE_RECOVERY = 4'd5,
		REG_READ_SAMPLE    = 4'd6,
		REG_READ_TAIL      = 4'd7
	} reg_idx_t;

	// Command codes carried with each tick.
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_RESET = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} opcode_t;

	// Phases of the bus sequencer.
	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_WAIT = 4'd2,
		PH_RST_TAIL = 4'd3,
		PH_W_LOW    = 4'd4,
		PH_W_REL    = 4'd5,
		PH_R_LOW    = 4'd6,
		PH_R_WAIT   = 4'd7,
		PH_R_TAIL   = 4'd8
	} phase_t;

	// Register values after reset, in index order.
	localparam cfg_file_t CfgDefaults = {
		10'd50,  // read tail
		10'd2,   // read sample
		10'd1,   // write recovery
		10'd50,  // long low
		10'd1,   // short low
		10'd410, // reset tail
		10'd70,  // presence wait
		10'd480  // reset low
	};

	// One result word.
	typedef struct packed {
		logic                drive_low;
		logic                busy_res;
		logic                done_res;
		logic                presence;
		logic [ByteBits-1:0] read_byte;
	} result_t;

	// Timer load for a phase of the given length; a length of zero acts as one.
	function automatic ticks_t phase_load(input ticks_t len);
		ticks_t load;
		load = (len == '0) ? '0 : len - ticks_t'(1);
		return load;
	endfunction

endpackage

// ===== hdl/owb_core.sv =====
// ----------------------------------------------------------------------------
// owb_core
// Bus sequencer state and its next-state logic, advanced once per tick.
// ----------------------------------------------------------------------------
module owb_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,       // consume one tick
	input  owb_pkg::opcode_t               opcode,
	input  logic [owb_pkg::ByteBits-1:0]   write_byte,
	input  logic                           line_level,
	input  owb_pkg::cfg_file_t             cfg,
	output owb_pkg::result_t               result
);

	owb_pkg::phase_t                 phase_q, phase_d;
	owb_pkg::ticks_t                 timer_q, timer_d;
	logic [owb_pkg::BitCntW-1:0]     bits_q, bits_d;
	logic [owb_pkg::ByteBits-1:0]    shift_q, shift_d;
	logic                            presence_q, presence_d;
	logic [owb_pkg::ByteBits-1:0]    hold_q, hold_d;
	logic                            done;

	// Next state for one tick.
	always_comb begin
		phase_d    = phase_q;
		timer_d    = timer_q;
		bits_d     = bits_q;
		shift_d    = shift_q;
		presence_d = presence_q;
		hold_d     = hold_q;
		done       = 1'b0;

		if (phase_q == owb_pkg::PH_IDLE) begin
			case (opcode)
				owb_pkg::OP_RESET: begin
					phase_d = owb_pkg::PH_RST_LOW;
					timer_d = owb_pkg::phase_load(cfg[owb_pkg::REG_RESET_LOW]);
				end
				owb_pkg::OP_WRITE: begin
					shift_d = write_byte;
					bits_d  = owb_pkg::BitCntW'(owb_pkg::ByteBits);
					phase_d = owb_pkg::PH_W_LOW;
					timer_d = owb_pkg::phase_load(write_byte[0] ?
						cfg[owb_pkg::REG_SHORT_LOW] : cfg[owb_pkg::REG_LONG_LOW]);
				end
				owb_pkg::OP_READ: begin
					shift_d = '0;
					bits_d  = owb_pkg::BitCntW'(owb_pkg::ByteBits);
					phase_d = owb_pkg::PH_R_LOW;
					timer_d = owb_pkg::phase_load(cfg[owb_pkg::REG_SHORT_LOW]);
				end
				default: begin
				end
			endcase
		end else if (timer_q != '0) begin
			timer_d = timer_q - owb_pkg::ticks_t'(1);
		end else begin
			unique case (phase_q)
				owb_pkg::PH_RST_LOW: begin
					phase_d = owb_pkg::PH_RST_WAIT;
					timer_d = owb_pkg::phase_load(cfg[owb_pkg::REG_PRESENCE_WAIT]);
				end
				owb_pkg::PH_RST_WAIT: begin
					presence_d = ~line_level;
					phase_d    = owb_pkg::PH_RST_TAIL;
					timer_d    = owb_pkg::phase_load(cfg[owb_pkg::REG_RESET_TAIL]);
				end
				owb_pkg::PH_W_LOW: begin
					phase_d = owb_pkg::PH_W_REL;
					timer_d = owb_pkg::phase_load(shift_q[0] ?
						cfg[owb_pkg::REG_LONG_LOW] : cfg[owb_pkg::REG_WRITE_RECOVERY]);
				end
				owb_pkg::PH_W_REL: begin
					shift_d = shift_q >> 1;
					if (bits_q <= owb_pkg::BitCntW'(1)) begin
						bits_d  = '0;
						phase_d = owb_pkg::PH_IDLE;
						done    = 1'b1;
					end else begin
						// Next slot is set by the bit that has just moved down.
						bits_d  = bits_q - owb_pkg::BitCntW'(1);
						phase_d = owb_pkg::PH_W_LOW;
						timer_d = owb_pkg::phase_load(shift_q[1] ?
							cfg[owb_pkg::REG_SHORT_LOW] : cfg[owb_pkg::REG_LONG_LOW]);
					end
				end
				owb_pkg::PH_R_LOW: begin
					phase_d = owb_pkg::PH_R_WAIT;
					timer_d = owb_pkg::phase_load(cfg[owb_pkg::REG_READ_SAMPLE]);
				end
				owb_pkg::PH_R_WAIT: begin
					// Sampled bit enters at the top, so the byte lands LSB first.
					shift_d = {line_level, shift_q[owb_pkg::ByteBits-1:1]};
					phase_d = owb_pkg::PH_R_TAIL;
					timer_d = owb_pkg::phase_load(cfg[owb_pkg::REG_READ_TAIL]);
				end
				owb_pkg::PH_R_TAIL: begin
					if (bits_q <= owb_pkg::BitCntW'(1)) begin
						bits_d  = '0;
						hold_d  = shift_q;
						phase_d = owb_pkg::PH_IDLE;
						done    = 1'b1;
					end else begin
						bits_d  = bits_q - owb_pkg::BitCntW'(1);
						phase_d = owb_pkg::PH_R_LOW;
						timer_d = owb_pkg::phase_load(cfg[owb_pkg::REG_SHORT_LOW]);
					end
				end
				default: begin
					// End of the reset tail, or a phase code with no meaning.
					phase_d = owb_pkg::PH_IDLE;
					done    = 1'b1;
				end
			endcase
		end
	end

	// Result word from the state after this tick.
	always_comb begin
		result.drive_low = (phase_d == owb_pkg::PH_RST_LOW) ||
			(phase_d == owb_pkg::PH_W_LOW) || (phase_d == owb_pkg::PH_R_LOW);
		result.busy_res  = (phase_d != owb_pkg::PH_IDLE);
		result.done_res  = done;
		result.presence  = presence_d;
		result.read_byte = hold_d;
	end

	// Sequencer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= owb_pkg::PH_IDLE;
			timer_q    <= '0;
			bits_q     <= '0;
			shift_q    <= '0;
			presence_q <= 1'b0;
			hold_q     <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			timer_q    <= timer_d;
			bits_q     <= bits_d;
			shift_q    <= shift_d;
			presence_q <= presence_d;
			hold_q     <= hold_d;
		end
	end

endmodule

// ===== hdl/one_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master advanced by one microsecond tick word per input transfer.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents
//  s_axis    in         opcode, write_byte, line_level (one tick)
//  m_axis    out        drive_low, busy_res, done_res, presence, read_byte
//  cfg       in         register index and 10-bit slot time
//
// One tick word is taken per cycle while s_tready is high; its result passes
// through the input register and then the result register.
// The sequencer state moves only when a word passes from the input register
// to the result register, so a stall on m_axis freezes it.
// s_tready stays high while the result register is free or being emptied.
// Reset returns the sequencer to idle and the slot times to their defaults.
// ----------------------------------------------------------------------------
module one_wire_bus_master (
	input  logic                         clk,
	input  logic                         arst_n,
	// Tick input.
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [15:0]                  s_tdata,   // opcode[1:0], write_byte[9:2],
	                                                // line_level[10], zeros above
	// Result output.
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [15:0]                  m_tdata,   // drive_low[0], busy_res[1],
	                                                // done_res[2], presence[3],
	                                                // read_byte[11:4], zeros above
	// Register writes.
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [owb_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [owb_pkg::TimerW-1:0]   cfg_data
);

	logic                          valid_s1;
	owb_pkg::opcode_t              opcode_s1;
	logic [owb_pkg::ByteBits-1:0]  wbyte_s1;
	logic                          line_s1;
	logic                          out_valid_q;
	owb_pkg::result_t              out_q;
	owb_pkg::result_t              result;
	owb_pkg::cfg_file_t            cfg_q;
	logic                          advance;
	logic                          take;

	// A word leaves the input register when the result register can take it.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign take     = s_tvalid && s_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			opcode_s1 <= owb_pkg::opcode_t'(s_tdata[1:0]);
			wbyte_s1  <= s_tdata[9:2];
			line_s1   <= s_tdata[10];
		end
	end

	// Slot time registers; indexes past the file are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= owb_pkg::CfgDefaults;
		end else if (cfg_valid && (cfg_index <= owb_pkg::REG_READ_TAIL)) begin
			cfg_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	// Sequencer.
	owb_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.opcode     (opcode_s1),
		.write_byte (wbyte_s1),
		.line_level (line_s1),
		.cfg        (cfg_q),
		.result     (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_q.read_byte, out_q.presence, out_q.done_res,
		out_q.busy_res, out_q.drive_low};

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 1-Wire bus master. Tick words are driven on the
// input stream and every result word is checked field by field against a
// tick-level sequencer model, kept in step at each accepted tick, or a pinned word.
// A short scripted sequence at short slot times comes first. Random command
// streams follow under several register settings: all zero, all one and small
// random values, and a bus reset is started at the largest values. Both
// streams idle at random.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 20000;
	localparam int unsigned DrainGap   = 8;
	localparam int unsigned HoldCycles = 300;
	localparam int unsigned HoldAfter  = 600;
	localparam int unsigned ScriptLen  = 16;
	localparam int unsigned StreamLen  = 64;
	localparam int unsigned LongTicks  = 40;

	// Result word laid out as on m_tdata, lowest field last.
	typedef struct packed {
		logic [owb_pkg::ByteBits-1:0] read_byte;
		logic                         presence;
		logic                         done_res;
		logic                         busy_res;
		logic                         drive_low;
	} bus_word_t;

	// One scripted tick; settle keeps ticking at the same level until idle.
	typedef struct {
		owb_pkg::opcode_t             op;
		logic [owb_pkg::ByteBits-1:0] data;
		logic                         level;
		bit                           settle;
		bit                           typed;
		bus_word_t                    want;
	} script_row_t;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         s_tvalid  = 1'b0;
	logic                         s_tready;
	logic [15:0]                  s_tdata   = '0;
	logic                         m_tvalid;
	logic                         m_tready  = 1'b0;
	logic [15:0]                  m_tdata;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [owb_pkg::CfgIdxW-1:0]  cfg_index = '0;
	logic [owb_pkg::TimerW-1:0]   cfg_data  = '0;

	// Model of the sequencer.
	owb_pkg::ticks_t              slot_time [owb_pkg::NumRegs];
	owb_pkg::phase_t              bus_phase;
	owb_pkg::ticks_t              bus_timer;
	logic [owb_pkg::BitCntW-1:0]  bits_left;
	logic [owb_pkg::ByteBits-1:0] shift_byte;
	logic                         presence_seen;
	logic [owb_pkg::ByteBits-1:0] last_read;

	bus_word_t           words_due [$];
	int unsigned         words_seen = 0;
	int unsigned         error_count = 0;
	bit                  steady = 1'b0;
	bit                  hold_done = 1'b0;
	bit                  pin_on = 1'b0;
	bus_word_t           pin_word = '0;

	// Scripted opening: read_byte, presence, done, busy, drive in each want.
	script_row_t script [ScriptLen] = '{
		'{owb_pkg::OP_TICK,  8'h00, 1'b1, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{owb_pkg::OP_TICK,  8'hFF, 1'b0, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{owb_pkg::OP_RESET, 8'h00, 1'b0, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
		'{owb_pkg::OP_WRITE, 8'hAA, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{owb_pkg::OP_TICK,  8'h00, 1'b1, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{owb_pkg::OP_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{owb_pkg::OP_WRITE, 8'h00, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{owb_pkg::OP_READ,  8'h00, 1'b1, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{owb_pkg::OP_TICK,  8'h55, 1'b0, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{owb_pkg::OP_READ,  8'h00, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{owb_pkg::OP_TICK,  8'hC3, 1'b1, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{owb_pkg::OP_RESET, 8'h00, 1'b1, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{owb_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{owb_pkg::OP_WRITE, 8'h5A, 1'b1, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{owb_pkg::OP_READ,  8'h00, 1'b1, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{owb_pkg::OP_RESET, 8'h81, 1'b0, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}}
	};

	one_wire_bus_master u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock, 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Enter a phase lasting the given slot time; a zero time counts as one tick.
	function automatic void enter_slot(input owb_pkg::phase_t ph, input owb_pkg::reg_idx_t r);
		bus_phase = ph;
		bus_timer = (slot_time[r] == '0) ? '0 : slot_time[r] - owb_pkg::ticks_t'(1);
	endfunction

	// Advance the sequencer model by one tick and return the result word.
	function automatic bus_word_t bus_tick(input owb_pkg::opcode_t op,
			input logic [owb_pkg::ByteBits-1:0] data, input logic level);
		bus_word_t w;
		logic      fin;
		fin = 1'b0;
		if (bus_phase == owb_pkg::PH_IDLE) begin
			case (op)
				owb_pkg::OP_RESET: enter_slot(owb_pkg::PH_RST_LOW, owb_pkg::REG_RESET_LOW);
				owb_pkg::OP_WRITE: begin
					shift_byte = data;
					bits_left  = owb_pkg::BitCntW'(owb_pkg::ByteBits);
					enter_slot(owb_pkg::PH_W_LOW, shift_byte[0] ?
						owb_pkg::REG_SHORT_LOW : owb_pkg::REG_LONG_LOW);
				end
				owb_pkg::OP_READ: begin
					shift_byte = '0;
					bits_left  = owb_pkg::BitCntW'(owb_pkg::ByteBits);
					enter_slot(owb_pkg::PH_R_LOW, owb_pkg::REG_SHORT_LOW);
				end
				default: ;
			endcase
		end else if (bus_timer != '0) begin
			bus_timer = bus_timer - owb_pkg::ticks_t'(1);
		end else begin
			case (bus_phase)
				owb_pkg::PH_RST_LOW:
					enter_slot(owb_pkg::PH_RST_WAIT, owb_pkg::REG_PRESENCE_WAIT);
				owb_pkg::PH_RST_WAIT: begin
					// A device answers by holding the line low.
					presence_seen = ~level;
					enter_slot(owb_pkg::PH_RST_TAIL, owb_pkg::REG_RESET_TAIL);
				end
				owb_pkg::PH_W_LOW:
					enter_slot(owb_pkg::PH_W_REL, shift_byte[0] ?
						owb_pkg::REG_LONG_LOW : owb_pkg::REG_WRITE_RECOVERY);
				owb_pkg::PH_W_REL: begin
					shift_byte = shift_byte >> 1;
					if (bits_left <= 1) begin
						bits_left = '0;
						bus_phase = owb_pkg::PH_IDLE;
						fin       = 1'b1;
					end else begin
						bits_left = bits_left - 1'b1;
						enter_slot(owb_pkg::PH_W_LOW, shift_byte[0] ?
							owb_pkg::REG_SHORT_LOW : owb_pkg::REG_LONG_LOW);
					end
				end
				owb_pkg::PH_R_LOW: enter_slot(owb_pkg::PH_R_WAIT, owb_pkg::REG_READ_SAMPLE);
				owb_pkg::PH_R_WAIT: begin
					// Sampled bits come in at the top, so the byte ends up LSB first.
					shift_byte = {level, shift_byte[owb_pkg::ByteBits-1:1]};
					enter_slot(owb_pkg::PH_R_TAIL, owb_pkg::REG_READ_TAIL);
				end
				owb_pkg::PH_R_TAIL: begin
					if (bits_left <= 1) begin
						bits_left = '0;
						last_read = shift_byte;
						bus_phase = owb_pkg::PH_IDLE;
						fin       = 1'b1;
					end else begin
						bits_left = bits_left - 1'b1;
						enter_slot(owb_pkg::PH_R_LOW, owb_pkg::REG_SHORT_LOW);
					end
				end
				default: begin
					bus_phase = owb_pkg::PH_IDLE;
					fin       = 1'b1;
				end
			endcase
		end
		w.drive_low = (bus_phase == owb_pkg::PH_RST_LOW) || (bus_phase == owb_pkg::PH_W_LOW) ||
			(bus_phase == owb_pkg::PH_R_LOW);
		w.busy_res  = (bus_phase != owb_pkg::PH_IDLE);
		w.done_res  = fin;
		w.presence  = presence_seen;
		w.read_byte = last_read;
		return w;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		error_count++;
	endtask

	// Scoreboard: results are checked before this edge's tick word is predicted.
	always @(posedge clk) begin : scoreboard
		bus_word_t got;
		bus_word_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[11:0];
				words_seen++;
				if (words_due.size() == 0) begin
					report_mismatch("unexpected word", int'(got), 0);
				end else begin
					want = words_due.pop_front();
					if (got.drive_low !== want.drive_low)
						report_mismatch("drive_low", int'(got.drive_low),
							int'(want.drive_low));
					if (got.busy_res !== want.busy_res)
						report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
					if (got.done_res !== want.done_res)
						report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
					if (got.presence !== want.presence)
						report_mismatch("presence", int'(got.presence), int'(want.presence));
					if (got.read_byte !== want.read_byte)
						report_mismatch("read_byte", int'(got.read_byte),
							int'(want.read_byte));
					if (m_tdata[15:12] !== '0)
						report_mismatch("pad bits", int'(m_tdata[15:12]), 0);
				end
			end
			if (s_tvalid && s_tready) begin
				want = bus_tick(owb_pkg::opcode_t'(s_tdata[1:0]), s_tdata[9:2], s_tdata[10]);
				if (pin_on)
					want = pin_word;
				words_due.push_back(want);
			end
		end
	end

	// Result sink: random back-pressure, one long hold-off, steady stretches.
	initial begin : sink
		int unsigned held;
		held = 0;
		forever begin
			@(negedge clk);
			if (!hold_done && words_seen >= HoldAfter) begin
				m_tready <= 1'b0;
				held++;
				if (held == HoldCycles)
					hold_done = 1'b1;
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 14);
			end
		end
	end

	// Watchdog.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// Offer one tick word; called and returns at a falling edge.
	task automatic offer_tick(input owb_pkg::opcode_t op,
			input logic [owb_pkg::ByteBits-1:0] data, input logic level,
			input bit pinned = 1'b0, input bus_word_t pin = '0);
		while (!steady && $urandom_range(99) < 14) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		pin_on   = pinned;
		pin_word = pin;
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, level, data, op};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		pin_on = 1'b0;
	endtask

	// Keep ticking until the model says the operation has finished.
	task automatic run_to_idle(input bit fixed, input logic level);
		while (bus_phase != owb_pkg::PH_IDLE)
			offer_tick(owb_pkg::OP_TICK, 8'($urandom_range(255)),
				fixed ? level : 1'($urandom_range(1)));
	endtask

	// Stop sending and wait for every outstanding result word.
	task automatic drain_results;
		s_tvalid <= 1'b0;
		while (words_due.size() != 0)
			@(negedge clk);
		repeat (DrainGap) @(negedge clk);
	endtask

	task automatic write_reg(input logic [owb_pkg::CfgIdxW-1:0] idx,
			input owb_pkg::ticks_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx < owb_pkg::NumRegs)
			slot_time[idx[2:0]] = value;
		@(negedge clk);
	endtask

	// Load a full set of slot times while the bus is idle, plus one stray index.
	task automatic load_timing(input owb_pkg::ticks_t vals [owb_pkg::NumRegs]);
		owb_pkg::reg_idx_t r;
		drain_results();
		r = r.first();
		do begin
			write_reg(r, vals[r]);
			r = r.next();
		end while (r != r.first());
		write_reg(owb_pkg::CfgIdxW'($urandom_range(owb_pkg::NumRegs,
			(1 << owb_pkg::CfgIdxW) - 1)), owb_pkg::ticks_t'($urandom_range(1023)));
		cfg_valid <= 1'b0;
	endtask

	// Random command stream: mostly commands from idle, some stray commands while busy.
	task automatic random_stream(input int n, input bit pause_midway);
		owb_pkg::opcode_t op;
		for (int i = 0; i < n; i++) begin
			if (bus_phase == owb_pkg::PH_IDLE)
				op = ($urandom_range(99) < 70) ? owb_pkg::opcode_t'($urandom_range(
					owb_pkg::OP_RESET, owb_pkg::OP_READ)) : owb_pkg::OP_TICK;
			else
				op = ($urandom_range(99) < 15) ?
					owb_pkg::opcode_t'($urandom_range(owb_pkg::OP_READ)) : owb_pkg::OP_TICK;
			offer_tick(op, 8'($urandom_range(255)), 1'($urandom_range(1)));
			if (pause_midway && i == n / 2)
				drain_results();
		end
		run_to_idle(1'b0, 1'b0);
	endtask

	// Main sequence.
	initial begin : stimulus
		owb_pkg::ticks_t timing [owb_pkg::NumRegs];
		for (int i = 0; i < owb_pkg::NumRegs; i++)
			slot_time[i] = owb_pkg::CfgDefaults[i];
		bus_phase     = owb_pkg::PH_IDLE;
		bus_timer     = '0;
		bits_left     = '0;
		shift_byte    = '0;
		presence_seen = 1'b0;
		last_read     = '0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Short slot times keep the scripted operations brief.
		for (int i = 0; i < owb_pkg::NumRegs; i++)
			timing[i] = owb_pkg::ticks_t'(2);
		load_timing(timing);

		// Scripted part.
		foreach (script[i]) begin
			offer_tick(script[i].op, script[i].data, script[i].level, script[i].typed,
				script[i].want);
			if (script[i].settle)
				run_to_idle(1'b1, script[i].level);
		end

		// Random part under a range of slot-time settings.
		for (int ph = 0; ph < 7; ph++) begin
			for (int i = 0; i < owb_pkg::NumRegs; i++) begin
				case (ph)
					1:       timing[i] = '0;
					2:       timing[i] = owb_pkg::ticks_t'(1);
					4:       timing[i] = owb_pkg::ticks_t'($urandom_range(20));
					default: timing[i] = owb_pkg::ticks_t'($urandom_range(1, 8));
				endcase
			end
			load_timing(timing);
			steady = (ph == 3);
			random_stream(StreamLen, ph == 5);
			steady = 1'b0;
		end

		// Largest slot times: the start of a long bus reset.
		for (int i = 0; i < owb_pkg::NumRegs; i++)
			timing[i] = '1;
		load_timing(timing);
		offer_tick(owb_pkg::OP_RESET, 8'($urandom_range(255)), 1'($urandom_range(1)));
		repeat (LongTicks)
			offer_tick(owb_pkg::OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));

		drain_results();
		if (words_due.size() != 0)
			report_mismatch("words left over", words_due.size(), 0);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
